// File: hw/rtl/plid_pkg.sv
// Shared types and codes for the positional list block.
package plid_pkg;

	// Request codes carried on the mode field.
	localparam logic [2:0] MODE_INS_FRONT = 3'd0;
	localparam logic [2:0] MODE_INS_BACK  = 3'd1;
	localparam logic [2:0] MODE_DEL_FRONT = 3'd2;
	localparam logic [2:0] MODE_DEL_BACK  = 3'd3;
	localparam logic [2:0] MODE_INS_AT    = 3'd4;
	localparam logic [2:0] MODE_DEL_AT    = 3'd5;
	localparam logic [2:0] MODE_READ_AT   = 3'd6;

	// Result status codes.
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_BADPOS = 2'd1;
	localparam logic [1:0] STAT_FULL   = 2'd2;
	localparam logic [1:0] STAT_EMPTY  = 2'd3;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic execute;
	} cmd_t;

endpackage

// File: hw/rtl/plid_ctrl.sv
// Controller state machine for the positional list: sequences capture, execute and output.
module plid_ctrl import plid_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_valid_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				// Execution waits until the output register is free or being emptied.
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EXEC: begin
				cmd.execute = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		if (cmd.execute) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: hw/rtl/plid_datapath.sv
// Datapath for the positional list: entry cells, occupancy count and result registers.
module plid_datapath import plid_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic [2:0]         mode,
	input  logic signed [31:0] value,
	input  logic [4:0]         position,
	output logic [1:0]         status,
	output logic [4:0]         element_count,
	output logic signed [31:0] read_value
);

	localparam int OCC_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CMP_W = ((OCC_W > 5) ? OCC_W : 5) + 1;
	localparam logic [OCC_W-1:0] CAP_OCC = OCC_W'(CAPACITY);

	logic [2:0]       mode_q;
	logic [31:0]      value_q;
	logic [4:0]       position_q;
	logic [OCC_W-1:0] occ_q;
	logic [31:0]      entries_q [CAPACITY];
	logic [1:0]       status_q;
	logic [4:0]       count_q;
	logic [31:0]      read_q;

	logic [CMP_W-1:0] occ_w;
	logic [CMP_W-1:0] pos_w;
	logic [CMP_W-1:0] pos_m1;
	logic [CMP_W-1:0] idx;
	logic [CMP_W-1:0] occ_next;
	logic             full;
	logic             empty;
	logic             do_ins;
	logic             do_del;
	logic [1:0]       stat_d;
	logic [31:0]      rd_d;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q     <= mode;
			value_q    <= value;
			position_q <= position;
		end
	end

	always_comb begin
		occ_w  = CMP_W'(occ_q);
		pos_w  = CMP_W'(position_q);
		pos_m1 = pos_w - CMP_W'(1);
		full   = (occ_q == CAP_OCC);
		empty  = (occ_q == '0);
		do_ins = 1'b0;
		do_del = 1'b0;
		idx    = '0;
		stat_d = STAT_OK;
		rd_d   = '0;
		case (mode_q)
			MODE_INS_FRONT, MODE_INS_BACK: begin
				if (full) begin
					stat_d = STAT_FULL;
				end else begin
					do_ins = 1'b1;
					idx    = (mode_q == MODE_INS_FRONT) ? '0 : occ_w;
				end
			end
			MODE_DEL_FRONT, MODE_DEL_BACK: begin
				if (empty) begin
					stat_d = STAT_EMPTY;
				end else begin
					do_del = 1'b1;
					idx    = (mode_q == MODE_DEL_FRONT) ? '0 : occ_w - CMP_W'(1);
				end
			end
			MODE_INS_AT: begin
				if (full) begin
					stat_d = STAT_FULL;
				end else if (pos_w == '0 || pos_w > occ_w + CMP_W'(1)) begin
					stat_d = STAT_BADPOS;
				end else begin
					do_ins = 1'b1;
					idx    = pos_m1;
				end
			end
			MODE_DEL_AT: begin
				if (empty) begin
					stat_d = STAT_EMPTY;
				end else if (pos_w == '0 || pos_w > occ_w) begin
					stat_d = STAT_BADPOS;
				end else begin
					do_del = 1'b1;
					idx    = pos_m1;
				end
			end
			MODE_READ_AT: begin
				if (pos_w == '0 || pos_w > occ_w) begin
					stat_d = STAT_BADPOS;
				end else begin
					rd_d = entries_q[pos_m1[IDX_W-1:0]];
				end
			end
			default: begin
				stat_d = STAT_OK;
			end
		endcase
		if (do_ins) begin
			occ_next = occ_w + CMP_W'(1);
		end else if (do_del) begin
			occ_next = occ_w - CMP_W'(1);
		end else begin
			occ_next = occ_w;
		end
	end

	// Every cell decides on its own from a compare of its index with the target slot.
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		localparam logic [CMP_W-1:0] KW = CMP_W'(k);
		always_ff @(posedge clk) begin
			if (cmd.execute) begin
				if (do_ins) begin
					if (KW == idx) begin
						entries_q[k] <= value_q;
					end else if (KW > idx) begin
						if (k > 0) entries_q[k] <= entries_q[(k > 0) ? k - 1 : 0];
					end
				end else if (do_del) begin
					if (KW >= idx && k < CAPACITY - 1) begin
						entries_q[k] <= entries_q[(k < CAPACITY - 1) ? k + 1 : k];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (cmd.execute) begin
			occ_q <= occ_next[OCC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			status_q <= stat_d;
			count_q  <= occ_next[4:0];
			read_q   <= rd_d;
		end
	end

	assign status        = status_q;
	assign element_count = count_q;
	assign read_value    = read_q;

endmodule

// File: hw/rtl/positional_list_insert_delete.sv
// Positional list of signed 32-bit entries: insert, delete and read by position.
// Flow: each input beat is captured, then executed into the output registers.
// A new request is taken only once the previous one has executed; the execute step stalls
// while an earlier result still sits unaccepted in the output register.
// Reset: arst_n clears the occupancy count and the handshake state; entries stay undefined.
module positional_list_insert_delete import plid_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         mode,
	input  logic signed [31:0] value,
	input  logic [4:0]         position,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [4:0]         element_count,
	output logic signed [31:0] read_value
);

	localparam logic [4:0] CAP_LO = 5'(CAPACITY % 32);

	cmd_t cmd;

	plid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	plid_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.mode          (mode),
		.value         (value),
		.position      (position),
		.status        (status),
		.element_count (element_count),
		.read_value    (read_value)
	);

	// A list reported empty holds nothing.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_EMPTY |-> element_count == 5'd0)
		else $error("empty status with nonzero count");

	// A list reported full holds exactly its capacity.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_FULL |-> element_count == CAP_LO)
		else $error("full status with wrong count");

	// Read data is only nonzero on a successful request.
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_value != 0 |-> status == STAT_OK)
		else $error("read value on failed request");

	// An executed request always presents a result in the next cycle.
	a_exec_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |=> out_valid)
		else $error("executed request produced no result");

endmodule
